### rtl/mwee_pkg.sv
// Shared types and constants for the Microwire serial EEPROM unit.
package mwee_pkg;

  localparam int unsigned STORE_BYTES = 128;
  localparam int unsigned ROWS        = STORE_BYTES / 2;
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned CAS_W       = 9;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DATA_W      = 2 * BYTE_W;
  localparam int unsigned COUNT_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] CMD_BITS_WORD   = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] CMD_BITS_BYTE   = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] DATA_BITS_WORD  = COUNT_W'(DATA_W);
  localparam logic [COUNT_W-1:0] DATA_BITS_BYTE  = COUNT_W'(BYTE_W);
  localparam logic [ROW_W-1:0]   ROW_LAST        = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    PIN_CS   = 2'd0,
    PIN_CLK  = 2'd1,
    PIN_DI   = 2'd2,
    PIN_NONE = 2'd3
  } pin_sel_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_CMD,
    PH_READ,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_ERASE,
    CMD_WRAL,
    CMD_ERAL,
    CMD_LOCK,
    CMD_UNLOCK
  } cmd_e;

  typedef enum logic [1:0] {
    MW_EXT   = 2'd0,
    MW_WRITE = 2'd1,
    MW_READ  = 2'd2,
    MW_ERASE = 2'd3
  } mw_op_e;

  typedef enum logic [1:0] {
    SUB_LOCK   = 2'd0,
    SUB_WRAL   = 2'd1,
    SUB_ERAL   = 2'd2,
    SUB_UNLOCK = 2'd3
  } mw_sub_e;

  typedef enum logic [2:0] {
    DS_HOLD,
    DS_CLEAR,
    DS_LOAD,
    DS_SHIFT_ONE,
    DS_SHIFT_DI
  } ds_op_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_CELL,
    MEM_WR_CELL_ONES,
    MEM_WR_CELL_DATA,
    MEM_RD_ROW,
    MEM_WR_ROW_ONES,
    MEM_WR_ROW_AND
  } mem_op_e;

  typedef struct packed {
    logic    word_mode;
    logic    di;
    logic    cas_clr;
    logic    cas_shift;
    logic    decode_load;
    logic    bump;
    ds_op_e  ds_op;
    mem_op_e mem_op;
    logic    row_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic    cmd_done;
    logic    data_done;
    logic    count_zero;
    mw_op_e  op;
    mw_sub_e sub;
    logic    ds_msb;
    logic    row_last;
  } dp_stat_t;

endpackage

### rtl/mwee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mwee_dp.sv
// Datapath: command/address and data shift registers, bit counter and the two byte banks.
module mwee_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwee_pkg::dp_cmd_t  cmd_i,
  output mwee_pkg::dp_stat_t stat_o
);

  logic [mwee_pkg::CAS_W-1:0]   cas_q, cas_d;
  logic [mwee_pkg::COUNT_W-1:0] count_q, count_d;
  logic [mwee_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [mwee_pkg::DATA_W-1:0]  ds_q, ds_d;
  logic [mwee_pkg::ROW_W-1:0]   row_q, row_d;

  logic                          re;
  logic [mwee_pkg::ROW_W-1:0]    raddr;
  logic                          we_hi, we_lo;
  logic [mwee_pkg::ROW_W-1:0]    waddr;
  logic [mwee_pkg::BYTE_W-1:0]   wd_hi, wd_lo;
  logic [mwee_pkg::BYTE_W-1:0]   rd_hi, rd_lo;
  logic [mwee_pkg::BYTE_W-1:0]   rd_byte, mask_hi;
  logic [mwee_pkg::DATA_W-1:0]   cell_val;
  logic [mwee_pkg::ROW_W-1:0]    cell_row;
  mwee_pkg::mw_op_e              op;

  assign op       = cmd_i.word_mode ? mwee_pkg::mw_op_e'(cas_q[7:6])
                                    : mwee_pkg::mw_op_e'(cas_q[8:7]);
  assign cell_row = cmd_i.word_mode ? addr_q[mwee_pkg::ROW_W-1:0]
                                    : addr_q[mwee_pkg::ADDR_W-1:1];
  assign cell_val = (cmd_i.mem_op == mwee_pkg::MEM_WR_CELL_ONES) ? '1 : ds_q;
  assign rd_byte  = addr_q[0] ? rd_lo : rd_hi;
  assign mask_hi  = cmd_i.word_mode ? ds_q[mwee_pkg::DATA_W-1:mwee_pkg::BYTE_W]
                                    : ds_q[mwee_pkg::BYTE_W-1:0];

  always_comb begin
    re    = 1'b0;
    raddr = row_q;
    we_hi = 1'b0;
    we_lo = 1'b0;
    waddr = row_q;
    wd_hi = '1;
    wd_lo = '1;
    case (cmd_i.mem_op)
      mwee_pkg::MEM_RD_CELL: begin
        re    = 1'b1;
        raddr = cell_row;
      end
      mwee_pkg::MEM_WR_CELL_ONES, mwee_pkg::MEM_WR_CELL_DATA: begin
        waddr = cell_row;
        if (cmd_i.word_mode) begin
          we_hi = 1'b1;
          we_lo = 1'b1;
          wd_hi = cell_val[mwee_pkg::DATA_W-1:mwee_pkg::BYTE_W];
          wd_lo = cell_val[mwee_pkg::BYTE_W-1:0];
        end else begin
          we_hi = ~addr_q[0];
          we_lo = addr_q[0];
          wd_hi = cell_val[mwee_pkg::BYTE_W-1:0];
          wd_lo = cell_val[mwee_pkg::BYTE_W-1:0];
        end
      end
      mwee_pkg::MEM_RD_ROW: begin
        re = 1'b1;
      end
      mwee_pkg::MEM_WR_ROW_ONES: begin
        we_hi = 1'b1;
        we_lo = 1'b1;
      end
      mwee_pkg::MEM_WR_ROW_AND: begin
        we_hi = 1'b1;
        we_lo = 1'b1;
        wd_hi = rd_hi & mask_hi;
        wd_lo = rd_lo & ds_q[mwee_pkg::BYTE_W-1:0];
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_comb begin
    cas_d   = cas_q;
    count_d = count_q;
    addr_d  = addr_q;
    ds_d    = ds_q;
    row_d   = row_q;

    if (cmd_i.cas_clr) begin
      cas_d = '0;
    end else if (cmd_i.cas_shift) begin
      cas_d = {cas_q[mwee_pkg::CAS_W-2:0], cmd_i.di};
    end

    if (cmd_i.cas_clr || cmd_i.decode_load) begin
      count_d = '0;
    end else if (cmd_i.bump && (count_q != mwee_pkg::COUNT_MAX)) begin
      count_d = count_q + mwee_pkg::COUNT_W'(1);
    end

    if (cmd_i.decode_load) begin
      if (op == mwee_pkg::MW_EXT) begin
        addr_d = '0;
      end else if (cmd_i.word_mode) begin
        addr_d = {1'b0, cas_q[mwee_pkg::ROW_W-1:0]};
      end else begin
        addr_d = cas_q[mwee_pkg::ADDR_W-1:0];
      end
    end

    case (cmd_i.ds_op)
      mwee_pkg::DS_CLEAR:     ds_d = '0;
      mwee_pkg::DS_LOAD:      ds_d = cmd_i.word_mode ? {rd_hi, rd_lo}
                                                     : {rd_byte, {mwee_pkg::BYTE_W{1'b1}}};
      mwee_pkg::DS_SHIFT_ONE: ds_d = {ds_q[mwee_pkg::DATA_W-2:0], 1'b1};
      mwee_pkg::DS_SHIFT_DI:  ds_d = {ds_q[mwee_pkg::DATA_W-2:0], cmd_i.di};
      default:                ds_d = ds_q;
    endcase

    if (cmd_i.row_inc) begin
      row_d = row_q + mwee_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cas_q   <= '0;
      count_q <= '0;
      addr_q  <= '0;
      ds_q    <= '0;
      row_q   <= '0;
    end else begin
      cas_q   <= cas_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      ds_q    <= ds_d;
      row_q   <= row_d;
    end
  end

  mwee_ram #(
    .Width(mwee_pkg::BYTE_W),
    .Depth(mwee_pkg::ROWS)
  ) u_bank_hi (
    .clk_i  (clk_i),
    .we_i   (we_hi),
    .waddr_i(waddr),
    .wdata_i(wd_hi),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_hi)
  );

  mwee_ram #(
    .Width(mwee_pkg::BYTE_W),
    .Depth(mwee_pkg::ROWS)
  ) u_bank_lo (
    .clk_i  (clk_i),
    .we_i   (we_lo),
    .waddr_i(waddr),
    .wdata_i(wd_lo),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_lo)
  );

  always_comb begin
    stat_o.cmd_done   = count_q == (cmd_i.word_mode ? mwee_pkg::CMD_BITS_WORD
                                                    : mwee_pkg::CMD_BITS_BYTE);
    stat_o.data_done  = count_q == (cmd_i.word_mode ? mwee_pkg::DATA_BITS_WORD
                                                    : mwee_pkg::DATA_BITS_BYTE);
    stat_o.count_zero = count_q == '0;
    stat_o.op         = op;
    stat_o.sub        = cmd_i.word_mode ? mwee_pkg::mw_sub_e'(cas_q[5:4])
                                        : mwee_pkg::mw_sub_e'(cas_q[6:5]);
    stat_o.ds_msb     = ds_q[mwee_pkg::DATA_W-1];
    stat_o.row_last   = row_q == mwee_pkg::ROW_LAST;
  end

endmodule

### rtl/mwee_ctrl.sv
// Controller: handshakes, pin event detection, protocol phases and memory sequencing.
module mwee_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic               pin_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               data_out_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output mwee_pkg::dp_cmd_t  cmd_o,
  input  mwee_pkg::dp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_RDLOAD,
    S_PUT_ONES,
    S_PUT_DATA,
    S_FILL,
    S_AND_RD,
    S_AND_WR,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  mwee_pkg::phase_e  phase_q, phase_d;
  mwee_pkg::cmd_e    cmd_q, cmd_d, dec_cmd;
  logic              locked_q, locked_d;
  logic              cs_q, cs_d;
  logic              clk_q, clk_d;
  logic              di_q, di_d;
  logic              mode_q, mode_d;
  logic [1:0]        opc_q, opc_d;
  logic              lvl_q, lvl_d;
  logic              out_valid_q, out_valid_d;
  logic              data_out_q, data_out_d;
  logic              cs_rise, cs_fall, clk_rise;

  assign cs_rise  = (opc_q == mwee_pkg::PIN_CS) && lvl_q && !cs_q;
  assign cs_fall  = (opc_q == mwee_pkg::PIN_CS) && !lvl_q && cs_q;
  assign clk_rise = (opc_q == mwee_pkg::PIN_CLK) && lvl_q && !clk_q;

  always_comb begin
    case (stat_i.op)
      mwee_pkg::MW_WRITE: dec_cmd = mwee_pkg::CMD_WRITE;
      mwee_pkg::MW_READ:  dec_cmd = mwee_pkg::CMD_READ;
      mwee_pkg::MW_ERASE: dec_cmd = mwee_pkg::CMD_ERASE;
      default: begin
        case (stat_i.sub)
          mwee_pkg::SUB_LOCK: dec_cmd = mwee_pkg::CMD_LOCK;
          mwee_pkg::SUB_WRAL: dec_cmd = mwee_pkg::CMD_WRAL;
          mwee_pkg::SUB_ERAL: dec_cmd = mwee_pkg::CMD_ERAL;
          default:            dec_cmd = mwee_pkg::CMD_UNLOCK;
        endcase
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    locked_d    = locked_q;
    cs_d        = cs_q;
    clk_d       = clk_q;
    di_d        = di_q;
    mode_d      = mode_q;
    opc_d       = opc_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q;
    data_out_d  = data_out_q;

    cmd_o             = '0;
    cmd_o.word_mode   = mode_q;
    cmd_o.di          = di_q;
    cmd_o.ds_op       = mwee_pkg::DS_HOLD;
    cmd_o.mem_op      = mwee_pkg::MEM_NONE;

    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_op  = mwee_pkg::MEM_WR_ROW_ONES;
        cmd_o.row_inc = 1'b1;
        if (stat_i.row_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          opc_d   = opcode_i;
          lvl_d   = pin_level_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_EMIT;
        if (opc_q == mwee_pkg::PIN_CS) begin
          cs_d = lvl_q;
        end
        if (opc_q == mwee_pkg::PIN_CLK) begin
          clk_d = lvl_q;
        end
        if (opc_q == mwee_pkg::PIN_DI) begin
          di_d = lvl_q;
        end
        case (phase_q)
          mwee_pkg::PH_IDLE: begin
            if (cs_rise) begin
              phase_d = mwee_pkg::PH_START;
            end
          end
          mwee_pkg::PH_START: begin
            if (clk_rise && di_q) begin
              cmd_o.cas_clr = 1'b1;
              phase_d       = mwee_pkg::PH_CMD;
            end else if (cs_fall) begin
              phase_d = mwee_pkg::PH_IDLE;
            end
          end
          mwee_pkg::PH_CMD: begin
            if (clk_rise) begin
              cmd_o.cas_shift = 1'b1;
              cmd_o.bump      = 1'b1;
              state_d         = S_CHECK;
            end else if (cs_fall) begin
              phase_d = mwee_pkg::PH_IDLE;
            end
          end
          mwee_pkg::PH_READ: begin
            if (clk_rise) begin
              if (stat_i.count_zero) begin
                cmd_o.mem_op = mwee_pkg::MEM_RD_CELL;
                state_d      = S_RDLOAD;
              end else begin
                cmd_o.ds_op = mwee_pkg::DS_SHIFT_ONE;
                cmd_o.bump  = 1'b1;
              end
            end else if (cs_fall) begin
              phase_d = mwee_pkg::PH_IDLE;
            end
          end
          mwee_pkg::PH_DATA: begin
            if (clk_rise) begin
              cmd_o.ds_op = mwee_pkg::DS_SHIFT_DI;
              cmd_o.bump  = 1'b1;
              state_d     = S_CHECK;
            end else if (cs_fall) begin
              phase_d = mwee_pkg::PH_IDLE;
            end
          end
          default: begin
            if (cs_fall) begin
              phase_d = mwee_pkg::PH_IDLE;
            end
          end
        endcase
      end
      S_CHECK: begin
        state_d = S_EMIT;
        if (phase_q == mwee_pkg::PH_CMD) begin
          if (stat_i.cmd_done) begin
            cmd_o.decode_load = 1'b1;
            cmd_o.ds_op       = mwee_pkg::DS_CLEAR;
            cmd_d             = dec_cmd;
            case (dec_cmd)
              mwee_pkg::CMD_READ: phase_d = mwee_pkg::PH_READ;
              mwee_pkg::CMD_WRITE, mwee_pkg::CMD_WRAL: phase_d = mwee_pkg::PH_DATA;
              mwee_pkg::CMD_ERASE: begin
                if (locked_q) begin
                  phase_d = mwee_pkg::PH_IDLE;
                end else begin
                  phase_d = mwee_pkg::PH_DONE;
                  state_d = S_PUT_ONES;
                end
              end
              mwee_pkg::CMD_ERAL: begin
                if (locked_q) begin
                  phase_d = mwee_pkg::PH_IDLE;
                end else begin
                  phase_d = mwee_pkg::PH_DONE;
                  state_d = S_FILL;
                end
              end
              mwee_pkg::CMD_LOCK: begin
                locked_d = 1'b1;
                phase_d  = mwee_pkg::PH_IDLE;
              end
              default: begin
                locked_d = 1'b0;
                phase_d  = mwee_pkg::PH_IDLE;
              end
            endcase
          end
        end else if (stat_i.data_done) begin
          if (locked_q) begin
            phase_d = mwee_pkg::PH_IDLE;
          end else begin
            phase_d = mwee_pkg::PH_DONE;
            state_d = (cmd_q == mwee_pkg::CMD_WRITE) ? S_PUT_DATA : S_AND_RD;
          end
        end
      end
      S_RDLOAD: begin
        cmd_o.ds_op = mwee_pkg::DS_LOAD;
        cmd_o.bump  = 1'b1;
        state_d     = S_EMIT;
      end
      S_PUT_ONES: begin
        cmd_o.mem_op = mwee_pkg::MEM_WR_CELL_ONES;
        state_d      = S_EMIT;
      end
      S_PUT_DATA: begin
        cmd_o.mem_op = mwee_pkg::MEM_WR_CELL_DATA;
        state_d      = S_EMIT;
      end
      S_FILL: begin
        cmd_o.mem_op  = mwee_pkg::MEM_WR_ROW_ONES;
        cmd_o.row_inc = 1'b1;
        if (stat_i.row_last) begin
          state_d = S_EMIT;
        end
      end
      S_AND_RD: begin
        cmd_o.mem_op = mwee_pkg::MEM_RD_ROW;
        state_d      = S_AND_WR;
      end
      S_AND_WR: begin
        cmd_o.mem_op  = mwee_pkg::MEM_WR_ROW_AND;
        cmd_o.row_inc = 1'b1;
        state_d       = stat_i.row_last ? S_EMIT : S_AND_RD;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          data_out_d  = !((phase_q == mwee_pkg::PH_READ) && !stat_i.ds_msb);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= mwee_pkg::PH_IDLE;
      cmd_q       <= mwee_pkg::CMD_NONE;
      locked_q    <= 1'b1;
      cs_q        <= 1'b0;
      clk_q       <= 1'b0;
      di_q        <= 1'b0;
      mode_q      <= 1'b1;
      opc_q       <= '0;
      lvl_q       <= 1'b0;
      out_valid_q <= 1'b0;
      data_out_q  <= 1'b1;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      locked_q    <= locked_d;
      cs_q        <= cs_d;
      clk_q       <= clk_d;
      di_q        <= di_d;
      mode_q      <= mode_d;
      opc_q       <= opc_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      data_out_q  <= data_out_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

endmodule

### rtl/microwire_serial_eeprom_unit.sv
// Top level of the Microwire serial EEPROM unit: controller plus datapath.
// A beat is accepted in S_IDLE and evaluated in S_EVAL, and its DO beat is offered from S_EMIT;
// clock edges that shift command or write-data bits also pass through S_CHECK, the read-word load
// through S_RDLOAD, and a single erase or write through S_CHECK and S_PUT_ONES or S_PUT_DATA.
// A DO beat left waiting stalls input. Erase-all adds a pass over the rows, one row per cycle;
// write-all adds one with a read and a write per row. Reset leaves the device idle, locked and in
// 16-bit word mode, then fills the store with ones in a pass during which no beat is taken.
module microwire_serial_eeprom_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic       pin_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       data_out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  mwee_pkg::dp_cmd_t  dp_cmd;
  mwee_pkg::dp_stat_t dp_stat;

  mwee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .pin_level_i(pin_level_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_out_o (data_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat)
  );

  mwee_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (dp_cmd),
    .stat_o(dp_stat)
  );

endmodule
